@@ src/memory_map_with_mmio_devices_core_assert.svh @@
// assertion macros shared by the rtl modules
// both sample on clk and are off while rst_n is low
`ifndef MEMORY_MAP_WITH_MMIO_DEVICES_CORE_ASSERT_SVH
`define MEMORY_MAP_WITH_MMIO_DEVICES_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define MMDEV_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define MMDEV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/mmdev_pkg.sv @@
package mmdev_pkg;

  // default region bases and receive fifo depth
  localparam int LOW_ROM_START_DEF  = 32768;
  localparam int PROGRAM_START_DEF  = 49152;
  localparam int MMIO_START_DEF     = 65024;
  localparam int HIGH_ROM_START_DEF = 65280;
  localparam int RX_DEPTH_DEF       = 16;

  localparam int SPACE         = 65536;
  localparam int SCRATCH_DEPTH = 256;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_KEY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_LIMIT = 1'b1;
  localparam logic [7:0]  UNLOCK_KEY_RST  = 8'd165;
  localparam logic [15:0] WRITE_LIMIT_RST = 16'd256;

  // mmio page offsets
  localparam logic [7:0] OFF_UART_DATA = 8'h00;
  localparam logic [7:0] OFF_UART_STAT = 8'h01;
  localparam logic [7:0] OFF_GPIO_VAL  = 8'h10;
  localparam logic [7:0] OFF_GPIO_DIR  = 8'h11;
  localparam logic [7:0] OFF_TIMER_LO  = 8'h20;
  localparam logic [7:0] OFF_TIMER_HI  = 8'h21;
  localparam logic [7:0] OFF_UNLOCK    = 8'hFE;

  localparam logic [7:0] UART_STAT_TX_READY = 8'h02;

  typedef enum logic [2:0] {
    ACT_READ   = 3'd0,
    ACT_WRITE  = 3'd1,
    ACT_TICK   = 3'd2,
    ACT_INJECT = 3'd3,
    ACT_LOAD   = 3'd4
  } act_t;

  // where the read byte of a transaction comes from
  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_RAM,
    SRC_LROM,
    SRC_PROG,
    SRC_HROM,
    SRC_PAGE
  } src_t;

  typedef enum logic [1:0] {
    PSRC_ZERO,
    PSRC_FIFO,
    PSRC_SCRATCH,
    PSRC_REG
  } psrc_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
  } clr_t;

  typedef struct packed {
    logic        rd;
    logic        wr;
    logic        tick;
    logic        inject;
    logic        prog_try;
    logic [7:0]  off;
    logic [7:0]  data;
    logic [15:0] cycles;
  } page_req_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_overflow;
    logic       prog_grant;
  } page_rsp_t;

  function automatic int aw_of(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  function automatic int span(input int lo, input int hi);
    return (hi > lo) ? (hi - lo) : 1;
  endfunction

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

@@ src/memory_map_with_mmio_devices_core.sv @@
// Byte-wide memory map with mmio devices: one transaction in, one result out.
// An item is taken every cycle unless the output stalls; its result passes the
// second stage and then the output register. The stores have one write and one
// read port with registered read data, which the second stage picks the result from.
// A full output register and a stalled second stage hold in_tready low.
// After reset a clearing pass zeroes ram, rom, program store and scratch
// memories, one entry of each per cycle, until the deepest of them has every
// entry cleared (32768 at the default bases); no item is taken meanwhile,
// while configuration writes are taken at any time.
module memory_map_with_mmio_devices_core #(
  parameter int LOW_ROM_START  = mmdev_pkg::LOW_ROM_START_DEF,
  parameter int PROGRAM_START  = mmdev_pkg::PROGRAM_START_DEF,
  parameter int MMIO_START     = mmdev_pkg::MMIO_START_DEF,
  parameter int HIGH_ROM_START = mmdev_pkg::HIGH_ROM_START_DEF,
  parameter int RX_DEPTH       = mmdev_pkg::RX_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [2:0] action, [18:3] address, [26:19] write_data, [58:27] tick_cycles
  input  logic [63:0]                      in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] read_data, [8] tx_valid, [16:9] tx_byte, [17] rx_overflow
  output logic [23:0]                      out_tdata,
  input  logic                             cfg_we,
  input  logic [mmdev_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mmdev_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int RAM_D  = LOW_ROM_START;
  localparam int LROM_D = mmdev_pkg::span(LOW_ROM_START, PROGRAM_START);
  localparam int PROG_D = mmdev_pkg::span(PROGRAM_START, MMIO_START);
  localparam int HROM_D = mmdev_pkg::span(HIGH_ROM_START, mmdev_pkg::SPACE);
  localparam int RAM_AW  = mmdev_pkg::aw_of(RAM_D);
  localparam int LROM_AW = mmdev_pkg::aw_of(LROM_D);
  localparam int PROG_AW = mmdev_pkg::aw_of(PROG_D);
  localparam int HROM_AW = mmdev_pkg::aw_of(HROM_D);
  localparam int CLR_D = mmdev_pkg::max2(mmdev_pkg::max2(RAM_D, LROM_D),
                         mmdev_pkg::max2(mmdev_pkg::max2(PROG_D, HROM_D),
                                         mmdev_pkg::SCRATCH_DEPTH));
  localparam int CLR_W = mmdev_pkg::aw_of(CLR_D);

  logic [15:0] low_base, prog_base, page_base, high_base;
  assign low_base  = 16'(LOW_ROM_START);
  assign prog_base = 16'(PROGRAM_START);
  assign page_base = 16'(MMIO_START);
  assign high_base = 16'(HIGH_ROM_START);

  // clearing pass
  logic             clr_busy_r;
  logic [CLR_W-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_cnt_r == CLR_W'(CLR_D - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + CLR_W'(1);
    end
  end

  // input fields
  mmdev_pkg::act_t act;
  logic [15:0] addr;
  logic [7:0]  wdata;
  logic [31:0] cycles;

  assign act    = mmdev_pkg::act_t'(in_tdata[2:0]);
  assign addr   = in_tdata[18:3];
  assign wdata  = in_tdata[26:19];
  assign cycles = in_tdata[58:27];

  // handshake and stage control
  logic in_acc;
  logic adv;
  logic s1_valid_r;
  logic out_valid_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !clr_busy_r && (!s1_valid_r || adv);
  assign in_acc    = in_tvalid && in_tready;

  // address decode
  logic is_rd, is_wr, is_load;
  logic lt_low, lt_prog, lt_mmio, lt_high;
  mmdev_pkg::src_t region;
  logic [15:0] off_lrom, off_prog, off_mmio, off_hrom;

  assign is_rd   = in_acc && (act == mmdev_pkg::ACT_READ);
  assign is_wr   = in_acc && (act == mmdev_pkg::ACT_WRITE);
  assign is_load = in_acc && (act == mmdev_pkg::ACT_LOAD);

  assign lt_low  = addr < low_base;
  assign lt_prog = addr < prog_base;
  assign lt_mmio = addr < page_base;
  assign lt_high = addr < high_base;

  assign off_lrom = addr - low_base;
  assign off_prog = addr - prog_base;
  assign off_mmio = addr - page_base;
  assign off_hrom = addr - high_base;

  always_comb begin
    priority if (lt_low) begin
      region = mmdev_pkg::SRC_RAM;
    end else if (lt_prog) begin
      region = mmdev_pkg::SRC_LROM;
    end else if (lt_mmio) begin
      region = mmdev_pkg::SRC_PROG;
    end else if (lt_high) begin
      region = mmdev_pkg::SRC_PAGE;
    end else begin
      region = mmdev_pkg::SRC_HROM;
    end
  end

  // mmio page
  mmdev_pkg::page_req_t preq;
  mmdev_pkg::page_rsp_t prsp;
  mmdev_pkg::clr_t      pclr;
  logic [7:0]           page_rdata;

  always_comb begin
    preq          = '0;
    preq.rd       = is_rd && (region == mmdev_pkg::SRC_PAGE);
    preq.wr       = is_wr && (region == mmdev_pkg::SRC_PAGE);
    preq.tick     = in_acc && (act == mmdev_pkg::ACT_TICK);
    preq.inject   = in_acc && (act == mmdev_pkg::ACT_INJECT);
    preq.prog_try = is_wr && (region == mmdev_pkg::SRC_PROG);
    preq.off      = off_mmio[7:0];
    preq.data     = wdata;
    preq.cycles   = cycles[15:0];
    pclr.en       = clr_busy_r;
    pclr.addr     = clr_cnt_r[7:0];
  end

  mmdev_page #(
    .RX_DEPTH (RX_DEPTH)
  ) u_page (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .clr        (pclr),
    .req        (preq),
    .rsp        (prsp),
    .page_rdata (page_rdata)
  );

  // main stores
  logic ram_we, lrom_we, prog_we, hrom_we;
  logic [7:0] st_wdata;
  logic [RAM_AW-1:0]  ram_waddr;
  logic [LROM_AW-1:0] lrom_waddr;
  logic [PROG_AW-1:0] prog_waddr;
  logic [HROM_AW-1:0] hrom_waddr;
  logic [7:0] ram_rdata, lrom_rdata, prog_rdata, hrom_rdata;

  assign st_wdata = clr_busy_r ? 8'd0 : wdata;

  assign ram_we  = clr_busy_r || (is_wr && (region == mmdev_pkg::SRC_RAM));
  assign lrom_we = clr_busy_r || (is_load && !lt_low && lt_prog);
  assign prog_we = clr_busy_r || prsp.prog_grant;
  assign hrom_we = clr_busy_r || (is_load && (region == mmdev_pkg::SRC_HROM));

  assign ram_waddr  = clr_busy_r ? clr_cnt_r[RAM_AW-1:0]  : addr[RAM_AW-1:0];
  assign lrom_waddr = clr_busy_r ? clr_cnt_r[LROM_AW-1:0] : off_lrom[LROM_AW-1:0];
  assign prog_waddr = clr_busy_r ? clr_cnt_r[PROG_AW-1:0] : off_prog[PROG_AW-1:0];
  assign hrom_waddr = clr_busy_r ? clr_cnt_r[HROM_AW-1:0] : off_hrom[HROM_AW-1:0];

  mmdev_ram #(.DEPTH(RAM_D), .AW(RAM_AW), .W(8)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (st_wdata),
    .re    (is_rd && (region == mmdev_pkg::SRC_RAM)),
    .raddr (addr[RAM_AW-1:0]),
    .rdata (ram_rdata)
  );

  mmdev_ram #(.DEPTH(LROM_D), .AW(LROM_AW), .W(8)) u_low_rom (
    .clk   (clk),
    .we    (lrom_we),
    .waddr (lrom_waddr),
    .wdata (st_wdata),
    .re    (is_rd && (region == mmdev_pkg::SRC_LROM)),
    .raddr (off_lrom[LROM_AW-1:0]),
    .rdata (lrom_rdata)
  );

  mmdev_ram #(.DEPTH(PROG_D), .AW(PROG_AW), .W(8)) u_prog (
    .clk   (clk),
    .we    (prog_we),
    .waddr (prog_waddr),
    .wdata (st_wdata),
    .re    (is_rd && (region == mmdev_pkg::SRC_PROG)),
    .raddr (off_prog[PROG_AW-1:0]),
    .rdata (prog_rdata)
  );

  mmdev_ram #(.DEPTH(HROM_D), .AW(HROM_AW), .W(8)) u_high_rom (
    .clk   (clk),
    .we    (hrom_we),
    .waddr (hrom_waddr),
    .wdata (st_wdata),
    .re    (is_rd && (region == mmdev_pkg::SRC_HROM)),
    .raddr (off_hrom[HROM_AW-1:0]),
    .rdata (hrom_rdata)
  );

  // second stage: waits for the registered read data
  mmdev_pkg::src_t s1_src_r;
  logic       s1_tx_valid_r;
  logic [7:0] s1_tx_byte_r;
  logic       s1_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_src_r      <= is_rd ? region : mmdev_pkg::SRC_ZERO;
      s1_tx_valid_r <= prsp.tx_valid;
      s1_tx_byte_r  <= prsp.tx_byte;
      s1_ovf_r      <= prsp.rx_overflow;
    end
  end

  logic [7:0] rd_byte;

  always_comb begin
    unique case (s1_src_r)
      mmdev_pkg::SRC_RAM:  rd_byte = ram_rdata;
      mmdev_pkg::SRC_LROM: rd_byte = lrom_rdata;
      mmdev_pkg::SRC_PROG: rd_byte = prog_rdata;
      mmdev_pkg::SRC_HROM: rd_byte = hrom_rdata;
      mmdev_pkg::SRC_PAGE: rd_byte = page_rdata;
      default:             rd_byte = 8'd0;
    endcase
  end

  // output register
  logic [23:0] out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_tdata_r <= {6'd0, s1_ovf_r, s1_tx_byte_r, s1_tx_valid_r, rd_byte};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

`include "memory_map_with_mmio_devices_core_assert.svh"

  `MMDEV_ASSERT(a_tx_no_read, out_tvalid && out_tdata[8], out_tdata[7:0] == 8'd0, "transmit result carries read data")
  `MMDEV_ASSERT(a_tx_ovf_excl, out_tvalid, !(out_tdata[8] && out_tdata[17]), "transmit and overflow in one result")
  `MMDEV_ASSERT_NEXT(a_accept_stage, in_acc, s1_valid_r, "accepted transaction lost before second stage")

endmodule

@@ src/mmdev_ram.sv @@
module mmdev_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int W     = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/mmdev_page.sv @@
module mmdev_page #(
  parameter int RX_DEPTH = mmdev_pkg::RX_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mmdev_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mmdev_pkg::CFG_DATA_W-1:0] cfg_data,
  input  mmdev_pkg::clr_t                  clr,
  input  mmdev_pkg::page_req_t             req,
  output mmdev_pkg::page_rsp_t             rsp,
  output logic [7:0]                       page_rdata
);

  localparam int HW = mmdev_pkg::aw_of(RX_DEPTH);
  localparam int CW = $clog2(RX_DEPTH + 1);

  logic [7:0]    unlock_key_r, unlock_key_nxt;
  logic [15:0]   write_limit_r, write_limit_nxt;
  logic [7:0]    gpio_val_r, gpio_val_nxt;
  logic [7:0]    gpio_dir_r, gpio_dir_nxt;
  logic [15:0]   timer_r, timer_nxt;
  logic          unlocked_r, unlocked_nxt;
  logic [15:0]   writes_left_r, writes_left_nxt;
  logic [HW-1:0] rx_head_r, rx_head_nxt;
  logic [CW-1:0] rx_count_r, rx_count_nxt;
  mmdev_pkg::psrc_t rsel_r, rsel_nxt;
  logic [7:0]    rreg_r, rreg_nxt;

  logic          fifo_empty;
  logic          fifo_full;
  logic          pop;
  logic          push;
  logic [CW:0]   tail_sum;
  logic [HW-1:0] tail;
  logic          scr_wr;
  logic          scr_rd;
  logic          scr_we;
  logic [7:0]    scr_waddr;
  logic [7:0]    scr_wdata;
  logic [7:0]    scr_rdata;
  logic [7:0]    fifo_rdata;
  logic [15:0]   wl_dec;

  assign fifo_empty = (rx_count_r == '0);
  assign fifo_full  = (rx_count_r >= CW'(RX_DEPTH));
  assign pop  = req.rd && (req.off == mmdev_pkg::OFF_UART_DATA) && !fifo_empty;
  assign push = req.inject && !fifo_full;

  // head plus count stays below twice the depth
  assign tail_sum = (CW+1)'(rx_head_r) + (CW+1)'(rx_count_r);
  assign tail = (tail_sum >= (CW+1)'(RX_DEPTH)) ? HW'(tail_sum - (CW+1)'(RX_DEPTH))
                                                 : HW'(tail_sum);

  assign wl_dec = writes_left_r - 16'd1;

  always_comb begin
    unlock_key_nxt  = unlock_key_r;
    write_limit_nxt = write_limit_r;
    gpio_val_nxt    = gpio_val_r;
    gpio_dir_nxt    = gpio_dir_r;
    timer_nxt       = timer_r;
    unlocked_nxt    = unlocked_r;
    writes_left_nxt = writes_left_r;
    rx_head_nxt     = rx_head_r;
    rx_count_nxt    = rx_count_r;
    rsel_nxt        = rsel_r;
    rreg_nxt        = rreg_r;
    scr_wr          = 1'b0;
    scr_rd          = 1'b0;
    rsp             = '0;

    if (cfg_we) begin
      unique case (cfg_index)
        mmdev_pkg::CFG_UNLOCK_KEY:  unlock_key_nxt  = cfg_data[7:0];
        mmdev_pkg::CFG_WRITE_LIMIT: write_limit_nxt = cfg_data;
        default: ;
      endcase
    end

    if (req.wr) begin
      unique case (req.off)
        mmdev_pkg::OFF_UART_DATA: begin
          rsp.tx_valid = 1'b1;
          rsp.tx_byte  = req.data;
        end
        mmdev_pkg::OFF_UART_STAT: ;
        mmdev_pkg::OFF_GPIO_VAL:  gpio_val_nxt = req.data;
        mmdev_pkg::OFF_GPIO_DIR:  gpio_dir_nxt = req.data;
        mmdev_pkg::OFF_TIMER_LO:  timer_nxt = {timer_r[15:8], req.data};
        mmdev_pkg::OFF_TIMER_HI:  timer_nxt = {req.data, timer_r[7:0]};
        mmdev_pkg::OFF_UNLOCK: begin
          if (req.data == unlock_key_r) begin
            unlocked_nxt    = 1'b1;
            writes_left_nxt = write_limit_r;
          end
        end
        default: scr_wr = 1'b1;
      endcase
    end

    if (req.rd) begin
      unique case (req.off)
        mmdev_pkg::OFF_UART_DATA: rsel_nxt = fifo_empty ? mmdev_pkg::PSRC_ZERO
                                                        : mmdev_pkg::PSRC_FIFO;
        mmdev_pkg::OFF_UART_STAT: begin
          rsel_nxt = mmdev_pkg::PSRC_REG;
          rreg_nxt = mmdev_pkg::UART_STAT_TX_READY | {7'd0, !fifo_empty};
        end
        mmdev_pkg::OFF_GPIO_VAL: begin
          rsel_nxt = mmdev_pkg::PSRC_REG;
          rreg_nxt = gpio_val_r;
        end
        mmdev_pkg::OFF_GPIO_DIR: begin
          rsel_nxt = mmdev_pkg::PSRC_REG;
          rreg_nxt = gpio_dir_r;
        end
        mmdev_pkg::OFF_TIMER_LO: begin
          rsel_nxt = mmdev_pkg::PSRC_REG;
          rreg_nxt = timer_r[7:0];
        end
        mmdev_pkg::OFF_TIMER_HI: begin
          rsel_nxt = mmdev_pkg::PSRC_REG;
          rreg_nxt = timer_r[15:8];
        end
        default: begin
          rsel_nxt = mmdev_pkg::PSRC_SCRATCH;
          scr_rd   = 1'b1;
        end
      endcase
    end

    if (req.tick) begin
      timer_nxt = timer_r + req.cycles;
    end

    if (req.inject && fifo_full) begin
      rsp.rx_overflow = 1'b1;
    end

    if (push) begin
      rx_count_nxt = rx_count_r + CW'(1);
    end else if (pop) begin
      rx_count_nxt = rx_count_r - CW'(1);
      rx_head_nxt  = (rx_head_r == HW'(RX_DEPTH - 1)) ? '0 : rx_head_r + HW'(1);
    end

    // program store write budget
    if (req.prog_try && unlocked_r && (writes_left_r != '0)) begin
      rsp.prog_grant  = 1'b1;
      writes_left_nxt = wl_dec;
      if (wl_dec == '0) begin
        unlocked_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unlock_key_r  <= mmdev_pkg::UNLOCK_KEY_RST;
      write_limit_r <= mmdev_pkg::WRITE_LIMIT_RST;
      gpio_val_r    <= '0;
      gpio_dir_r    <= '0;
      timer_r       <= '0;
      unlocked_r    <= 1'b0;
      writes_left_r <= '0;
      rx_head_r     <= '0;
      rx_count_r    <= '0;
      rsel_r        <= mmdev_pkg::PSRC_ZERO;
    end else begin
      unlock_key_r  <= unlock_key_nxt;
      write_limit_r <= write_limit_nxt;
      gpio_val_r    <= gpio_val_nxt;
      gpio_dir_r    <= gpio_dir_nxt;
      timer_r       <= timer_nxt;
      unlocked_r    <= unlocked_nxt;
      writes_left_r <= writes_left_nxt;
      rx_head_r     <= rx_head_nxt;
      rx_count_r    <= rx_count_nxt;
      rsel_r        <= rsel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rreg_r <= rreg_nxt;
  end

  assign scr_we    = clr.en || scr_wr;
  assign scr_waddr = clr.en ? clr.addr : req.off;
  assign scr_wdata = clr.en ? 8'd0 : req.data;

  mmdev_ram #(
    .DEPTH (mmdev_pkg::SCRATCH_DEPTH),
    .AW    (8),
    .W     (8)
  ) u_scratch (
    .clk   (clk),
    .we    (scr_we),
    .waddr (scr_waddr),
    .wdata (scr_wdata),
    .re    (scr_rd),
    .raddr (req.off),
    .rdata (scr_rdata)
  );

  mmdev_ram #(
    .DEPTH (RX_DEPTH),
    .AW    (HW),
    .W     (8)
  ) u_rx_fifo (
    .clk   (clk),
    .we    (push),
    .waddr (tail),
    .wdata (req.data),
    .re    (pop),
    .raddr (rx_head_r),
    .rdata (fifo_rdata)
  );

  always_comb begin
    unique case (rsel_r)
      mmdev_pkg::PSRC_FIFO:    page_rdata = fifo_rdata;
      mmdev_pkg::PSRC_SCRATCH: page_rdata = scr_rdata;
      mmdev_pkg::PSRC_REG:     page_rdata = rreg_r;
      default:                 page_rdata = 8'd0;
    endcase
  end

`include "memory_map_with_mmio_devices_core_assert.svh"

  `MMDEV_ASSERT(a_rx_count_bound, 1'b1, rx_count_r <= CW'(RX_DEPTH), "rx fifo count past depth")
  `MMDEV_ASSERT_NEXT(a_grant_spends, rsp.prog_grant, writes_left_r == $past(wl_dec), "write budget not spent")
  `MMDEV_ASSERT_NEXT(a_pop_count, pop, rx_count_r == $past(rx_count_r) - CW'(1), "pop did not drop count")

endmodule
